// ----- design/assert_macros.svh -----
// assertion helpers for the intersection top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SBI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sbi_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbi_pkg
// Widths, types and codes shared by the segment / oriented box test.
// ---------------------------------------------------------------------------
package sbi_pkg;

  // coordinates are Q11.10, axis components Q2.19
  localparam int COORD_BITS = 21;
  localparam int AXIS_BITS  = 21;
  localparam int AXIS_FRAC  = 19;
  localparam int CFG_W      = 63;
  localparam int THR_W      = 20;
  localparam int CFG_IDX_W  = 3;

  localparam int DIFF_W = COORD_BITS + 1;        // point minus centre
  localparam int PROD_W = DIFF_W + AXIS_BITS;    // one axis term
  localparam int P_W    = PROD_W + 2;            // projection on an axis
  localparam int D_W    = P_W + 1;               // projection difference
  localparam int H_W    = COORD_BITS + AXIS_FRAC; // half extent at projection scale
  localparam int MOP_W  = D_W + 1;               // multiplier operand
  localparam int MRES_W = 2 * MOP_W;             // multiplier result
  localparam int X_W    = MRES_W + 2;            // crossing test values
  localparam int MUL_LO_W = (MOP_W + 1) / 2;
  localparam int MUL_HI_W = MOP_W - MUL_LO_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [P_W-1:0]        pval_t;
  typedef logic signed [D_W-1:0]        dval_t;
  typedef logic signed [MOP_W-1:0]      mop_t;
  typedef logic signed [MRES_W-1:0]     mres_t;
  typedef logic signed [X_W-1:0]        xval_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER = 3'd0,
    CFG_AXIS_X = 3'd1,
    CFG_AXIS_Y = 3'd2,
    CFG_AXIS_Z = 3'd3,
    CFG_HALF   = 3'd4,
    CFG_THR    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CASE_MISS_FACE = 2'd0,
    CASE_INSIDE    = 2'd1,
    CASE_CROSS     = 2'd2,
    CASE_NO_CROSS  = 2'd3
  } case_code_t;

  // stage enables for the two multiplier register stages
  typedef struct packed {
    logic a;
    logic b;
  } mul_en_t;

  // per-item decision bits carried down the pipe
  typedef struct packed {
    logic       miss;
    logic       in_box;
    logic [5:0] face_ok;
  } tag_t;

endpackage

// ----- design/sbi_mul.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbi_mul
// Two-stage signed multiplier: sign-magnitude split into four half-width
// partial products, then summed and signed in the second stage.
// ---------------------------------------------------------------------------
module sbi_mul import sbi_pkg::*; (
  input  logic    clk,
  input  mul_en_t en,
  input  mop_t    op_a,
  input  mop_t    op_b,
  output mres_t   prod
);

  logic [MOP_W-1:0] mag_a, mag_b;
  logic [2*MUL_LO_W-1:0]        pp_ll_r, pp_ll_nxt;
  logic [MUL_LO_W+MUL_HI_W-1:0] pp_lh_r, pp_lh_nxt, pp_hl_r, pp_hl_nxt;
  logic [2*MUL_HI_W-1:0]        pp_hh_r, pp_hh_nxt;
  logic                         neg_r, neg_nxt;
  logic [MRES_W-1:0]            sum;
  mres_t                        prod_r, prod_nxt;

  always_comb begin
    mag_a = op_a[MOP_W-1] ? MOP_W'(-op_a) : MOP_W'(op_a);
    mag_b = op_b[MOP_W-1] ? MOP_W'(-op_b) : MOP_W'(op_b);
    neg_nxt   = op_a[MOP_W-1] ^ op_b[MOP_W-1];
    pp_ll_nxt = mag_a[MUL_LO_W-1:0] * mag_b[MUL_LO_W-1:0];
    pp_lh_nxt = mag_a[MUL_LO_W-1:0] * mag_b[MOP_W-1:MUL_LO_W];
    pp_hl_nxt = mag_a[MOP_W-1:MUL_LO_W] * mag_b[MUL_LO_W-1:0];
    pp_hh_nxt = mag_a[MOP_W-1:MUL_LO_W] * mag_b[MOP_W-1:MUL_LO_W];
  end

  always_ff @(posedge clk) begin
    if (en.a) begin
      pp_ll_r <= pp_ll_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_hh_r <= pp_hh_nxt;
      neg_r   <= neg_nxt;
    end
  end

  always_comb begin
    sum = MRES_W'(pp_ll_r)
        + (MRES_W'(pp_lh_r) << MUL_LO_W)
        + (MRES_W'(pp_hl_r) << MUL_LO_W)
        + (MRES_W'(pp_hh_r) << (2 * MUL_LO_W));
    prod_nxt = neg_r ? mres_t'(-sum) : mres_t'(sum);
  end

  always_ff @(posedge clk) begin
    if (en.b) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

// ----- design/segment_box_intersect_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_box_intersect_top
// Exact fixed-point test of a line segment against an oriented box.
// ---------------------------------------------------------------------------
// Takes one segment item per cycle while in_stall is low and returns one
// hit / case code item for each, in the order the items were accepted.
// The depth is set by the exact 47 x 47 bit crossing products, built from
// partial products of 24- and 23-bit halves over two register stages.
// Empty stages close up under a stall: input is taken until the pipe is full.
// Box registers must only be written while no item is in flight.
`include "assert_macros.svh"

module segment_box_intersect_top import sbi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  coord_t               in_start_x,
  input  coord_t               in_start_y,
  input  coord_t               in_start_z,
  input  coord_t               in_end_x,
  input  coord_t               in_end_y,
  input  coord_t               in_end_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic [1:0]           out_case_code
);

  localparam int NSTG = 9;

  // configuration
  logic [CFG_W-1:0] center_r;
  logic [CFG_W-1:0] axis_r [3];
  logic [CFG_W-1:0] half_r;
  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r  <= '0;
      axis_r[0] <= CFG_W'(64'd524288);
      axis_r[1] <= CFG_W'(64'd1099511627776);
      axis_r[2] <= CFG_W'(64'd2305843009213693952);
      half_r    <= '0;
      thr_r     <= THR_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER: center_r  <= cfg_wdata;
        CFG_AXIS_X: axis_r[0] <= cfg_wdata;
        CFG_AXIS_Y: axis_r[1] <= cfg_wdata;
        CFG_AXIS_Z: axis_r[2] <= cfg_wdata;
        CFG_HALF:   half_r    <= cfg_wdata;
        CFG_THR:    thr_r     <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: a stage moves when it is empty or its successor moves
  logic [NSTG-1:0] v_r, v_nxt, en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = in_valid;
    for (int i = 1; i < NSTG; i++) begin
      v_nxt[i] = v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_nxt[i];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NSTG-1];

  // config fields at their arithmetic widths
  coord_t          ctr [3];
  coord_t          ax  [3][3];
  logic [H_W-1:0]  hval [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ctr[i]  = coord_t'(center_r[i*COORD_BITS +: COORD_BITS]);
      hval[i] = {half_r[i*COORD_BITS +: COORD_BITS], {AXIS_FRAC{1'b0}}};
      for (int k = 0; k < 3; k++) begin
        ax[k][i] = coord_t'(axis_r[k][i*AXIS_BITS +: AXIS_BITS]);
      end
    end
  end

  // stage 1: endpoints relative to the centre
  coord_t in_a [3], in_b [3];
  diff_t  da_r [3], db_r [3], da_nxt [3], db_nxt [3];

  always_comb begin
    in_a[0] = in_start_x; in_a[1] = in_start_y; in_a[2] = in_start_z;
    in_b[0] = in_end_x;   in_b[1] = in_end_y;   in_b[2] = in_end_z;
    for (int i = 0; i < 3; i++) begin
      da_nxt[i] = DIFF_W'(in_a[i]) - DIFF_W'(ctr[i]);
      db_nxt[i] = DIFF_W'(in_b[i]) - DIFF_W'(ctr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      da_r <= da_nxt;
      db_r <= db_nxt;
    end
  end

  // stage 2: axis terms
  prod_t ta_r [3][3], tb_r [3][3], ta_nxt [3][3], tb_nxt [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        ta_nxt[k][i] = PROD_W'(ax[k][i]) * PROD_W'(da_r[i]);
        tb_nxt[k][i] = PROD_W'(ax[k][i]) * PROD_W'(db_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ta_r <= ta_nxt;
      tb_r <= tb_nxt;
    end
  end

  // stage 3: projections on the box axes
  pval_t pa_r [3], pb_r [3], pa_nxt [3], pb_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa_nxt[k] = P_W'(ta_r[k][0]) + P_W'(ta_r[k][1]) + P_W'(ta_r[k][2]);
      pb_nxt[k] = P_W'(tb_r[k][0]) + P_W'(tb_r[k][1]) + P_W'(tb_r[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
  end

  // stage 4: face classes, differences, early decisions
  dval_t            pa4_r [3], d4_r [3], pa4_nxt [3], d4_nxt [3];
  logic [D_W-1:0]   ad4_r [3], ad4_nxt [3];
  dval_t            hs [3];
  logic             ab_a [6], ab_b [6];
  logic [2:0]       na, nb;
  tag_t             tag4_nxt;

  always_comb begin
    tag4_nxt = '0;
    na = '0;
    nb = '0;
    for (int k = 0; k < 3; k++) begin
      hs[k]      = dval_t'({{(D_W-H_W){1'b0}}, hval[k]});
      pa4_nxt[k] = D_W'(pa_r[k]);
      d4_nxt[k]  = D_W'(pb_r[k]) - D_W'(pa_r[k]);
      ad4_nxt[k] = d4_nxt[k][D_W-1] ? D_W'(-d4_nxt[k]) : D_W'(d4_nxt[k]);
      // negative face first, then positive
      ab_a[2*k]   = pa4_nxt[k] < -hs[k];
      ab_b[2*k]   = D_W'(pb_r[k]) < -hs[k];
      ab_a[2*k+1] = pa4_nxt[k] > hs[k];
      ab_b[2*k+1] = D_W'(pb_r[k]) > hs[k];
    end
    for (int f = 0; f < 6; f++) begin
      if (ab_a[f] && ab_b[f]) begin
        tag4_nxt.miss = 1'b1;
      end
      na = na + 3'(ab_a[f]);
      nb = nb + 3'(ab_b[f]);
      tag4_nxt.face_ok[f] = (ab_a[f] != ab_b[f])
                         && (ad4_nxt[f/2] > D_W'(thr_r));
    end
    tag4_nxt.in_box = (na == 3'd0) || (nb == 3'd0);
  end

  tag_t tag_r [4:8];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pa4_r     <= pa4_nxt;
      d4_r      <= d4_nxt;
      ad4_r     <= ad4_nxt;
      tag_r[4]  <= tag4_nxt;
    end
    for (int s = 5; s <= 8; s++) begin
      if (en[s-1]) begin
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  // stages 5 and 6: crossing products
  mul_en_t mul_en;
  mres_t   pd [3][3], hd [3][3], hr [3][3];

  assign mul_en.a = en[4];
  assign mul_en.b = en[5];

  for (genvar k = 0; k < 3; k++) begin : g_k
    for (genvar j = 0; j < 3; j++) begin : g_j
      if (j != k) begin : g_off
        // projection j times difference k
        sbi_mul u_pd (
          .clk(clk), .en(mul_en),
          .op_a(MOP_W'(pa4_r[j])), .op_b(MOP_W'(d4_r[k])), .prod(pd[j][k]));
        // half extent k times difference j
        sbi_mul u_hd (
          .clk(clk), .en(mul_en),
          .op_a(mop_t'({{(MOP_W-H_W){1'b0}}, hval[k]})), .op_b(MOP_W'(d4_r[j])),
          .prod(hd[k][j]));
        // half extent j times |difference k|
        sbi_mul u_hr (
          .clk(clk), .en(mul_en),
          .op_a(mop_t'({{(MOP_W-H_W){1'b0}}, hval[j]})),
          .op_b(mop_t'({1'b0, ad4_r[k]})), .prod(hr[k][j]));
      end else begin : g_diag
        assign pd[j][k] = '0;
        assign hd[k][j] = '0;
        assign hr[k][j] = '0;
      end
    end
  end

  // stage 7: cross terms
  xval_t c7_r [3][3], hd7_r [3][3], hr7_r [3][3];
  xval_t c7_nxt [3][3], hd7_nxt [3][3], hr7_nxt [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        c7_nxt[k][j]  = X_W'(pd[j][k]) - X_W'(pd[k][j]);
        hd7_nxt[k][j] = X_W'(hd[k][j]);
        hr7_nxt[k][j] = X_W'(hr[k][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      c7_r  <= c7_nxt;
      hd7_r <= hd7_nxt;
      hr7_r <= hr7_nxt;
    end
  end

  // stage 8: signed crossing offsets per face, bounds both ways
  xval_t x8_r [6][3], x8_nxt [6][3];
  xval_t r8_r [3][3], nr8_r [3][3], nr8_nxt [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        x8_nxt[2*k][j]   = hd7_r[k][j] - c7_r[k][j];
        x8_nxt[2*k+1][j] = hd7_r[k][j] + c7_r[k][j];
        nr8_nxt[k][j]    = -hr7_r[k][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      x8_r  <= x8_nxt;
      r8_r  <= hr7_r;
      nr8_r <= nr8_nxt;
    end
  end

  // stage 9: bounds check and result register
  logic       in_b9 [6][3];
  logic       cross_hit;
  logic       hit_r, hit_nxt;
  case_code_t code_r, code_nxt;

  always_comb begin
    cross_hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int s = 0; s < 2; s++) begin
        for (int j = 0; j < 3; j++) begin
          in_b9[2*k+s][j] = x8_r[2*k+s][j][X_W-1] ? (x8_r[2*k+s][j] > nr8_r[k][j])
                                                  : (x8_r[2*k+s][j] < r8_r[k][j]);
        end
        // own axis never counts, so both other axes must be inside
        if (tag_r[8].face_ok[2*k+s]
            && in_b9[2*k+s][(k+1)%3] && in_b9[2*k+s][(k+2)%3]) begin
          cross_hit = 1'b1;
        end
      end
    end
    if (tag_r[8].miss) begin
      hit_nxt  = 1'b0;
      code_nxt = CASE_MISS_FACE;
    end else if (tag_r[8].in_box) begin
      hit_nxt  = 1'b1;
      code_nxt = CASE_INSIDE;
    end else if (cross_hit) begin
      hit_nxt  = 1'b1;
      code_nxt = CASE_CROSS;
    end else begin
      hit_nxt  = 1'b0;
      code_nxt = CASE_NO_CROSS;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      hit_r  <= hit_nxt;
      code_r <= code_nxt;
    end
  end

  assign out_hit       = hit_r;
  assign out_case_code = code_r;

  `SBI_ASSERT_NOW(a_hit_matches_code, out_valid,
    out_hit == (out_case_code == CASE_INSIDE || out_case_code == CASE_CROSS),
    "hit flag disagrees with case code")
  `SBI_ASSERT_NOW(a_stall_only_when_full, in_stall, &v_r,
    "input stalled while the pipe has an empty stage")
  `SBI_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v_r[0],
    "accepted item did not enter the first stage")

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment / oriented box intersection block.
// ---------------------------------------------------------------------------
// Segments go in through a queue-fed driver with random gaps, results are
// checked in order against an exact integer model of the box test. The run
// steps through several box setups: reset defaults, axis-aligned, rotated,
// skewed axes and register extremes. Both sides idle and stall at random.
module tb_top;
  import sbi_pkg::*;

  typedef struct {
    coord_t p [6];
  } segment_t;

  typedef struct {
    logic       hit;
    case_code_t code;
  } verdict_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  coord_t               in_start_x, in_start_y, in_start_z;
  coord_t               in_end_x, in_end_y, in_end_z;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_hit;
  logic [1:0]           out_case_code;

  segment_box_intersect_top dut (.*);

  // bench copy of the box registers
  logic [CFG_W-1:0] box_ctr, box_ax, box_ay, box_az, box_half;
  logic [THR_W-1:0] box_thr;

  segment_t segment_q [$];
  verdict_t verdict_q [$];
  int       n_err, n_sent, n_checked, idle_cycles;
  int       code_seen [4];
  int       gap_style;   // 0 no idling, 1 mixed
  int       send_gap, stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    int r;
    if (gap_style == 0) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic longint field_s(logic [CFG_W-1:0] r, int k);
    return longint'($signed(r[k*21 +: 21]));
  endfunction

  // exact box test at projection scale, no division
  function automatic verdict_t judge_segment(segment_t sg);
    longint a[3], b[3], c[3], hh[3], pa[3], pb[3], dd[3], e;
    longint sgn, den, num, aden;
    logic [CFG_W-1:0] axr;
    logic abv_a[3][2], abv_b[3][2];
    logic signed [127:0] w1, w2, w3, w4, x, lim;
    int na, nb, qty;
    verdict_t v;
    na = 0;
    nb = 0;
    v.hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i]  = longint'(sg.p[i]);
      b[i]  = longint'(sg.p[i+3]);
      c[i]  = field_s(box_ctr, i);
      hh[i] = longint'(box_half[i*21 +: 21]) << AXIS_FRAC;
    end
    for (int k = 0; k < 3; k++) begin
      axr = (k == 0) ? box_ax : (k == 1) ? box_ay : box_az;
      pa[k] = 0;
      pb[k] = 0;
      for (int i = 0; i < 3; i++) begin
        e = field_s(axr, i);
        pa[k] += e * (a[i] - c[i]);
        pb[k] += e * (b[i] - c[i]);
      end
      dd[k] = pb[k] - pa[k];
    end
    for (int k = 0; k < 3; k++) begin
      for (int s = 0; s < 2; s++) begin
        sgn = s ? 1 : -1;
        abv_a[k][s] = (sgn * pa[k] - hh[k]) > 0;
        abv_b[k][s] = (sgn * pb[k] - hh[k]) > 0;
        if (abv_a[k][s] && abv_b[k][s]) begin
          v.code = CASE_MISS_FACE;
          return v;
        end
        na += abv_a[k][s];
        nb += abv_b[k][s];
      end
    end
    if (na == 0 || nb == 0) begin
      v.hit  = 1'b1;
      v.code = CASE_INSIDE;
      return v;
    end
    for (int k = 0; k < 3; k++) begin
      for (int s = 0; s < 2; s++) begin
        if (abv_a[k][s] == abv_b[k][s]) continue;
        sgn  = s ? 1 : -1;
        den  = sgn * dd[k];
        aden = den < 0 ? -den : den;
        if (aden <= longint'(box_thr)) continue;
        num = sgn * pa[k] - hh[k];
        qty = 0;
        for (int j = 0; j < 3; j++) begin
          w1 = pa[j];
          w2 = den;
          w3 = num;
          w4 = dd[j];
          x  = w1 * w2 - w3 * w4;
          if (x < 0) x = -x;
          w1  = hh[j];
          w2  = aden;
          lim = w1 * w2;
          if (x < lim) qty++;
        end
        if (qty > 1) begin
          v.hit  = 1'b1;
          v.code = CASE_CROSS;
          return v;
        end
      end
    end
    v.code = CASE_NO_CROSS;
    return v;
  endfunction

  // driver
  always @(posedge clk) begin
    logic     sending;
    segment_t sg;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      sending = in_valid;
      if (in_valid && !in_stall) begin
        sg.p = '{in_start_x, in_start_y, in_start_z, in_end_x, in_end_y, in_end_z};
        verdict_q.push_back(judge_segment(sg));
        n_sent++;
        sending = 1'b0;
      end
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (segment_q.size() > 0) begin
          sg = segment_q.pop_front();
          in_start_x <= sg.p[0];
          in_start_y <= sg.p[1];
          in_start_z <= sg.p[2];
          in_end_x   <= sg.p[3];
          in_end_y   <= sg.p[4];
          in_end_z   <= sg.p[5];
          sending = 1'b1;
          send_gap <= draw_gap();
        end
      end
      in_valid <= sending;
    end
  end

  // monitor and result-side stall
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected item hit=%0b case=%0d", $time, out_hit, out_case_code);
          n_err++;
        end else begin
          want = verdict_q.pop_front();
          n_checked++;
          code_seen[want.code]++;
          if (out_hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_hit);
            n_err++;
          end
          if (out_case_code !== want.code) begin
            $display("%0t: case_code expected %0d actual %0d", $time, want.code,
                     out_case_code);
            n_err++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        stall_left <= draw_gap();
        out_stall  <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en ||
        (segment_q.size() == 0 && verdict_q.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("%0t: no progress, %0d items outstanding", $time, verdict_q.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CENTER: box_ctr  = val;
      CFG_AXIS_X: box_ax   = val;
      CFG_AXIS_Y: box_ay   = val;
      CFG_AXIS_Z: box_az   = val;
      CFG_HALF:   box_half = val;
      CFG_THR:    box_thr  = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (segment_q.size() > 0 || verdict_q.size() > 0 || in_valid) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [62:0] pack3(longint x, longint y, longint z);
    return {21'(z), 21'(y), 21'(x)};
  endfunction

  task automatic add_seg(longint ax, longint ay, longint az,
                         longint bx, longint by, longint bz);
    segment_t sg;
    sg.p = '{21'(ax), 21'(ay), 21'(az), 21'(bx), 21'(by), 21'(bz)};
    segment_q.push_back(sg);
  endtask

  // endpoints mostly around the box, some anywhere
  task automatic add_random(int count, int reach);
    longint cc[3], q[6];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 3; i++) cc[i] = field_s(box_ctr, i);
      for (int i = 0; i < 6; i++) begin
        if ($urandom_range(99) < 80)
          q[i] = cc[i % 3] + $signed($urandom_range(2 * reach)) - reach;
        else
          q[i] = $signed($urandom_range(21'h1FFFFF)) - 1048576;
      end
      add_seg(q[0], q[1], q[2], q[3], q[4], q[5]);
    end
  endtask

  localparam longint ONE = 1 << AXIS_FRAC;
  localparam longint CMIN = -1048576;
  localparam longint CMAX = 1048575;

  initial begin
    int hs, reach;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_start_x = '0; in_start_y = '0; in_start_z = '0;
    in_end_x = '0; in_end_y = '0; in_end_z = '0;
    out_stall = 1'b0;
    n_err = 0; n_sent = 0; n_checked = 0; idle_cycles = 0;
    send_gap = 0; stall_left = 0; gap_style = 1;
    code_seen = '{0, 0, 0, 0};
    box_ctr = '0; box_ax = 63'd524288; box_ay = 63'd1099511627776;
    box_az = 63'd2305843009213693952; box_half = '0; box_thr = 20'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // degenerate box from reset
    add_seg(0, 0, 0, 0, 0, 0);
    add_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    add_seg(-5, 0, 0, 5, 0, 0);
    wait_drained();

    // axis-aligned cube, half extent 4096 per axis: every outcome class
    write_reg(CFG_HALF, pack3(4096, 4096, 4096));
    write_reg(CFG_THR, CFG_W'(0));
    @(posedge clk) cfg_wr_en <= 1'b0;
    add_seg(0, 0, 0, 100, -100, 50);                   // both inside
    add_seg(10000, 0, 0, 20000, 500, 0);               // both beyond +x
    add_seg(-10000, 0, 0, -9000, 0, 0);                // both beyond -x
    add_seg(0, 0, 9000, 0, 0, 8000);                   // both beyond +z
    add_seg(0, -9000, 0, 0, -8000, 0);                 // both beyond -y
    add_seg(0, 0, 0, 20000, 0, 0);                     // one inside
    add_seg(-20000, 100, 0, 20000, 100, 0);            // through the box
    add_seg(0, -20000, 300, 0, 20000, 300);
    add_seg(300, 0, -20000, 300, 0, 20000);
    add_seg(-8000, 9000, 0, 9000, -8000, 0);           // crosses the box diagonally
    add_seg(-20000, 4096, 0, 20000, 4096, 0);          // grazes a face
    add_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    add_seg(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
    wait_drained();

    // max threshold: faces with a projected difference up to it count as parallel
    write_reg(CFG_THR, CFG_W'(20'hFFFFF));
    @(posedge clk) cfg_wr_en <= 1'b0;
    add_seg(-5000, 100, 0, 5000, 100, 0);
    add_seg(-4097, 0, 0, -4095, 0, 0);
    add_seg(-20000, 100, 0, 20000, 100, 0);
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      gap_style = (ph % 3 == 2) ? 0 : 1;
      hs = (ph == 7) ? 21'h1FFFFF : $urandom_range(20000, 0);
      reach = (ph == 7) ? 1048576 : 3 * hs + 2000;
      write_reg(CFG_CENTER, pack3($signed($urandom_range(400000)) - 200000,
                                  $signed($urandom_range(400000)) - 200000,
                                  $signed($urandom_range(400000)) - 200000));
      case (ph % 4)
        0: begin
          write_reg(CFG_AXIS_X, pack3(0, -ONE, 0));
          write_reg(CFG_AXIS_Y, pack3(0, 0, ONE));
          write_reg(CFG_AXIS_Z, pack3(-ONE, 0, 0));
        end
        1: begin
          // 45 degrees about z
          write_reg(CFG_AXIS_X, pack3(370727, 370727, 0));
          write_reg(CFG_AXIS_Y, pack3(-370727, 370727, 0));
          write_reg(CFG_AXIS_Z, pack3(0, 0, ONE));
        end
        2: begin
          write_reg(CFG_AXIS_X, pack3(CMIN, CMIN, CMIN));
          write_reg(CFG_AXIS_Y, pack3(CMAX, CMAX, CMAX));
          write_reg(CFG_AXIS_Z, pack3(CMIN, 0, CMAX));
        end
        default: begin
          write_reg(CFG_AXIS_X, CFG_W'({$urandom, $urandom}));
          write_reg(CFG_AXIS_Y, CFG_W'({$urandom, $urandom}));
          write_reg(CFG_AXIS_Z, CFG_W'({$urandom, $urandom}));
        end
      endcase
      if (ph == 8) write_reg(CFG_HALF, CFG_W'({$urandom, $urandom}));
      else write_reg(CFG_HALF, pack3(hs, $urandom_range(hs), $urandom_range(hs)));
      case (ph % 3)
        0: write_reg(CFG_THR, CFG_W'(0));
        1: write_reg(CFG_THR, CFG_W'($urandom_range(20'hFFFFF)));
        default: write_reg(CFG_THR, CFG_W'(20'hFFFFF));
      endcase
      @(posedge clk) cfg_wr_en <= 1'b0;
      add_random(135, (ph % 4 >= 2) ? 1048576 : reach);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("tb_top: %0d segments checked: %0d face misses, %0d inside, %0d crossings,",
             n_checked, code_seen[CASE_MISS_FACE], code_seen[CASE_INSIDE],
             code_seen[CASE_CROSS]);
    $display("tb_top: %0d no-crossing misses over 12 box setups", code_seen[CASE_NO_CROSS]);
    if (n_err == 0 && verdict_q.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
